FILE: hw/rtl/bump_allocator_with_marks_core_defines.svh
// ----------------------------------------------------------------------------
// Bump allocator assertion macros
// Shared property wrappers for the allocator core's checks.
// ----------------------------------------------------------------------------
`ifndef BUMP_ALLOCATOR_WITH_MARKS_CORE_DEFINES_SVH
`define BUMP_ALLOCATOR_WITH_MARKS_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BAM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define BAM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bam_pkg.sv
// ----------------------------------------------------------------------------
// Bump allocator package
// Item types, register codes, command and status codes for the allocator.
// ----------------------------------------------------------------------------
package bam_pkg;

	localparam int unsigned DATA_W = 32;

	// Command codes
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RESIZE  = 2'd1;
	localparam logic [1:0] CMD_SAVE    = 2'd2;
	localparam logic [1:0] CMD_RESTORE = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_OOM         = 2'd1;
	localparam logic [1:0] ST_NOT_LAST    = 2'd2;
	localparam logic [1:0] ST_BAD_RESTORE = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_BASE     = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;
	localparam logic [1:0] REG_ALIGN    = 2'd2;
	localparam logic [1:0] REG_GUARD    = 2'd3;

	// Register reset values
	localparam logic [31:0] BASE_RST     = 32'd0;
	localparam logic [31:0] CAPACITY_RST = 32'd65536;
	localparam logic [3:0]  ALIGN_RST    = 4'd6;
	localparam logic [11:0] GUARD_RST    = 12'd0;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] count;
		logic [31:0] elem_size;
		logic [31:0] target_address;
		logic [31:0] mark_top;
		logic [31:0] mark_last;
		logic        mark_last_valid;
	} bam_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
		logic [31:0] saved_last;
		logic        saved_last_valid;
		logic [31:0] used_bytes;
		logic [31:0] peak_bytes;
	} bam_rsp_t;

	// Request after the size multiply
	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] bytes;
		logic [31:0] target_address;
		logic [31:0] mark_top;
		logic [31:0] mark_last;
		logic        mark_last_valid;
	} bam_work_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] capacity;
		logic [3:0]  align_log2;
		logic [11:0] guard;
	} bam_cfg_t;

	typedef struct packed {
		logic [31:0] top;
		logic [31:0] last;
		logic        last_present;
		logic [31:0] peak;
	} bam_state_t;

endpackage

FILE: hw/rtl/bam_exec.sv
// ----------------------------------------------------------------------------
// Bump allocator command execution
// Applies one command to the allocator state: bound checks, padding,
// mark handling and peak tracking, all in combinational logic.
// ----------------------------------------------------------------------------
module bam_exec (
	input  bam_pkg::bam_cfg_t   cfg,
	input  bam_pkg::bam_state_t cur,
	input  bam_pkg::bam_work_t  work,
	output bam_pkg::bam_state_t nxt,
	output bam_pkg::bam_rsp_t   rsp
);
	import bam_pkg::*;

	logic [31:0] top_abs;
	logic [31:0] last_abs;
	logic [14:0] align_mask;
	logic [14:0] pad;
	logic [33:0] start;
	logic [65:0] alloc_end;
	logic        alloc_fit;
	logic [64:0] resize_end;
	logic        resize_fit;
	logic        last_match;
	logic [31:0] mark_off;
	logic [31:0] mark_last_off;
	logic        mark_bad;
	logic [31:0] grown_top;

	// Absolute addresses of top and last block
	assign top_abs  = cfg.base + cur.top;
	assign last_abs = cfg.base + cur.last;

	// Pad the top address up to the alignment, then leave the guard gap
	assign align_mask = (15'd1 << cfg.align_log2) - 15'd1;
	assign pad        = (15'd0 - top_abs[14:0]) & align_mask;
	assign start      = {2'b00, cur.top} + {19'd0, pad} + {22'd0, cfg.guard};

	// Exact bound checks against capacity
	assign alloc_end  = {32'd0, start} + {2'b00, work.bytes};
	assign alloc_fit  = alloc_end <= {34'd0, cfg.capacity};
	assign resize_end = {33'd0, cur.last} + {1'b0, work.bytes};
	assign resize_fit = resize_end <= {33'd0, cfg.capacity};
	assign last_match = cur.last_present && (last_abs == work.target_address);

	// Mark offsets relative to the region base
	assign mark_off      = work.mark_top - cfg.base;
	assign mark_last_off = work.mark_last - cfg.base;
	assign mark_bad      = mark_off > cur.top;

	// Top after a successful allocate or resize
	assign grown_top = (work.command == CMD_ALLOC) ? alloc_end[31:0] : resize_end[31:0];

	always_comb begin
		nxt                  = cur;
		rsp.status           = ST_OK;
		rsp.address          = '0;
		rsp.saved_last       = '0;
		rsp.saved_last_valid = 1'b0;

		case (work.command)
			CMD_ALLOC: begin
				if (alloc_fit) begin
					nxt.last         = start[31:0];
					nxt.last_present = 1'b1;
					nxt.top          = grown_top;
					rsp.address      = cfg.base + start[31:0];
				end else begin
					rsp.status = ST_OOM;
				end
			end
			CMD_RESIZE: begin
				if (!last_match) begin
					rsp.status = ST_NOT_LAST;
				end else if (resize_fit) begin
					nxt.top     = grown_top;
					rsp.address = last_abs;
				end else begin
					rsp.status = ST_OOM;
				end
			end
			CMD_SAVE: begin
				rsp.address = top_abs;
				if (cur.last_present) begin
					rsp.saved_last       = last_abs;
					rsp.saved_last_valid = 1'b1;
				end
			end
			CMD_RESTORE: begin
				if (mark_bad) begin
					rsp.status = ST_BAD_RESTORE;
				end else begin
					nxt.top          = mark_off;
					nxt.last_present = work.mark_last_valid;
					nxt.last         = work.mark_last_valid ? mark_last_off : 32'd0;
					rsp.address      = work.mark_top;
				end
			end
			default: begin
				rsp.status = ST_OK;
			end
		endcase

		// Track peak usage after growth only
		if ((work.command == CMD_ALLOC || work.command == CMD_RESIZE)
			&& rsp.status == ST_OK && nxt.top > cur.peak) begin
			nxt.peak = nxt.top;
		end

		rsp.used_bytes = nxt.top;
		rsp.peak_bytes = nxt.peak;
	end

endmodule

FILE: hw/rtl/bump_allocator_with_marks_core.sv
// ----------------------------------------------------------------------------
// Bump allocator with marks
// Arena allocator over one region: allocate, resize last, save and restore.
//
// Usage:
//   Requests enter on req/req_valid and are taken when req_stall is low.
//   Each request yields exactly one response on rsp/rsp_valid, taken when
//   rsp_stall is low. Responses come out in request order.
//   The first register holds the request with its count * elem_size
//   product, the second holds the response after the state update.
//   Throughput is one request per cycle while rsp_stall is low; the state
//   update (pad, guard, bound check, top and peak write) is combinational.
//   When the receiver stalls, the response holds and the block still takes
//   one more request into its first register; req_stall rises only while
//   both registers are full and the response is stalled.
//   Configuration writes on cfg_wr_en/cfg_index/cfg_data take effect at
//   once and are meant for idle periods.
//   Reset empties both registers, clears top, last block and peak, and
//   loads the register defaults (64-byte alignment, 64 KiB region).
// ----------------------------------------------------------------------------
module bump_allocator_with_marks_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bam_pkg::bam_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output bam_pkg::bam_rsp_t rsp,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import bam_pkg::*;

	`include "bump_allocator_with_marks_core_defines.svh"

	bam_cfg_t   cfg_q;
	bam_state_t state_q;
	bam_state_t state_nxt;
	bam_work_t  work_s1;
	logic       valid_s1;
	bam_rsp_t   rsp_q;
	bam_rsp_t   rsp_nxt;
	logic       rsp_valid_q;
	logic       out_free;
	logic       adv_s1;
	logic       take;

	// Handshake control
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign adv_s1    = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign take      = req_valid && !req_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base       <= BASE_RST;
			cfg_q.capacity   <= CAPACITY_RST;
			cfg_q.align_log2 <= ALIGN_RST;
			cfg_q.guard      <= GUARD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BASE:     cfg_q.base       <= cfg_data;
				REG_CAPACITY: cfg_q.capacity   <= cfg_data;
				REG_ALIGN:    cfg_q.align_log2 <= cfg_data[3:0];
				REG_GUARD:    cfg_q.guard      <= cfg_data[11:0];
				default:      cfg_q.base       <= cfg_q.base;
			endcase
		end
	end

	// Stage 1: register the request with its byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1.command         <= req.command;
			work_s1.bytes           <= {32'd0, req.count} * {32'd0, req.elem_size};
			work_s1.target_address  <= req.target_address;
			work_s1.mark_top        <= req.mark_top;
			work_s1.mark_last       <= req.mark_last;
			work_s1.mark_last_valid <= req.mark_last_valid;
		end
	end

	bam_exec u_exec (
		.cfg  (cfg_q),
		.cur  (state_q),
		.work (work_s1),
		.nxt  (state_nxt),
		.rsp  (rsp_nxt)
	);

	// Stage 2: update allocator state and register the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q     <= state_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= rsp_nxt;
		end
	end

	// Checks
	`BAM_ASSERT_NOW(a_top_below_peak, 1'b1, state_q.top <= state_q.peak, "top above peak")
	`BAM_ASSERT_NOW(a_fail_zero_addr, rsp_valid_q && rsp_q.status != ST_OK, rsp_q.address == 32'd0, "failed item carries an address")
	`BAM_ASSERT_NEXT(a_adv_gives_rsp, adv_s1, rsp_valid_q, "advanced item produced no response")

endmodule

FILE: tb/bump_allocator_with_marks_core_tb.sv
// ----------------------------------------------------------------------------
// Bump allocator with marks testbench
// Drives allocate, resize, save and restore items through the core under
// random sender bursts and receiver stalls. Each accepted item is run through
// a local arena model, and every response is compared field by field with the
// oldest prediction. Register settings change between phases while the core
// is idle. The phases cover address wrap, a one-byte region, the widest
// guard, 4096-byte alignment, and a region that shrinks below the current top.
// ----------------------------------------------------------------------------
module bump_allocator_with_marks_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bam_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MARKS_KEPT  = 16;

	// How an item's fields are completed when the driver picks it up
	typedef enum logic [2:0] {
		FIX_NONE,
		FIX_TARGET,
		FIX_MARK,
		FIX_FIT,
		FIX_OVER
	} fix_t;

	typedef struct {
		bam_req_t req;
		fix_t     fix;
	} pending_item_t;

	typedef struct packed {
		logic [31:0] top;
		logic [31:0] last;
		logic        valid;
	} mark_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	bam_req_t    req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	bam_rsp_t    rsp;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_BASE;
	logic [31:0] cfg_data  = '0;

	// Arena model: configuration and state
	logic [31:0] cfg_base  = BASE_RST;
	logic [31:0] cfg_cap   = CAPACITY_RST;
	logic [3:0]  cfg_align = ALIGN_RST;
	logic [11:0] cfg_guard = GUARD_RST;
	logic [31:0] arena_top        = '0;
	logic [31:0] arena_last       = '0;
	logic        arena_has_last   = 1'b0;
	logic [31:0] arena_high_water = '0;

	pending_item_t req_backlog[$];
	bam_rsp_t      expected_rsp[$];
	mark_t         saved_marks[$];
	int unsigned   reqs_open   = 0;
	int unsigned   errors      = 0;
	int unsigned   cycle_count = 0;
	logic          req_fire    = 1'b0;
	int unsigned   burst_left  = 1;
	int unsigned   gap_left    = 0;
	int unsigned   stall_left  = 0;

	bump_allocator_with_marks_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] abs_address(logic [31:0] off);
		return cfg_base + off;
	endfunction

	// Start offset of the next block: top, alignment padding, then guard
	function automatic logic [63:0] alloc_start();
		logic [31:0] amask;
		logic [31:0] pad;
		amask = (32'd1 << cfg_align) - 32'd1;
		pad = (32'd0 - abs_address(arena_top)) & amask;
		return {32'd0, arena_top} + {32'd0, pad} + {52'd0, cfg_guard};
	endfunction

	// Exact bound check, including a start already past the region end
	function automatic logic fits(logic [63:0] start, logic [63:0] bytes);
		if (start > {32'd0, cfg_cap})
			return 1'b0;
		return bytes <= ({32'd0, cfg_cap} - start);
	endfunction

	function automatic void raise_peak();
		if (arena_top > arena_high_water)
			arena_high_water = arena_top;
	endfunction

	// Advance the arena model by one item and return its response
	function automatic bam_rsp_t apply_request(bam_req_t r);
		bam_rsp_t    o;
		logic [63:0] bytes;
		logic [63:0] start;
		logic [31:0] moff;
		mark_t       m;
		o = '0;
		bytes = {32'd0, r.count} * {32'd0, r.elem_size};
		case (r.command)
			CMD_ALLOC: begin
				start = alloc_start();
				if (fits(start, bytes)) begin
					arena_last = start[31:0];
					arena_has_last = 1'b1;
					arena_top = start[31:0] + bytes[31:0];
					raise_peak();
					o.address = abs_address(arena_last);
				end else begin
					o.status = ST_OOM;
				end
			end
			CMD_RESIZE: begin
				if (!arena_has_last || abs_address(arena_last) != r.target_address) begin
					o.status = ST_NOT_LAST;
				end else if (fits({32'd0, arena_last}, bytes)) begin
					arena_top = arena_last + bytes[31:0];
					raise_peak();
					o.address = abs_address(arena_last);
				end else begin
					o.status = ST_OOM;
				end
			end
			CMD_SAVE: begin
				o.address = abs_address(arena_top);
				if (arena_has_last) begin
					o.saved_last = abs_address(arena_last);
					o.saved_last_valid = 1'b1;
				end
				m.top = o.address;
				m.last = o.saved_last;
				m.valid = o.saved_last_valid;
				saved_marks.push_back(m);
				if (saved_marks.size() > MARKS_KEPT)
					void'(saved_marks.pop_front());
			end
			default: begin
				moff = r.mark_top - cfg_base;
				if (moff > arena_top) begin
					o.status = ST_BAD_RESTORE;
				end else begin
					arena_top = moff;
					arena_has_last = r.mark_last_valid;
					arena_last = r.mark_last_valid ? (r.mark_last - cfg_base) : 32'd0;
					o.address = abs_address(arena_top);
				end
			end
		endcase
		o.used_bytes = arena_top;
		o.peak_bytes = arena_high_water;
		return o;
	endfunction

	// Fill in fields that depend on the arena state at the time of sending
	function automatic bam_req_t resolve_item(pending_item_t p);
		bam_req_t    r;
		logic [63:0] start;
		logic [63:0] room;
		mark_t       m;
		r = p.req;
		case (p.fix)
			FIX_TARGET: r.target_address = abs_address(arena_last);
			FIX_MARK: begin
				if (saved_marks.size() != 0) begin
					m = saved_marks[$urandom_range(0, saved_marks.size() - 1)];
					r.mark_top = m.top;
					r.mark_last = m.last;
					r.mark_last_valid = m.valid;
				end
			end
			FIX_FIT, FIX_OVER: begin
				start = alloc_start();
				room = (start > {32'd0, cfg_cap}) ? 64'd0 : ({32'd0, cfg_cap} - start);
				r.elem_size = 32'd1;
				if (p.fix == FIX_FIT) begin
					r.count = room[31:0];
				end else if (room < 64'hFFFF_FFFF) begin
					r.count = room[31:0] + 32'd1;
				end else begin
					r.elem_size = 32'd2;
					r.count = 32'h8000_0000;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	// Driver: hold a stalled item, otherwise send in bursts with gaps
	always @(negedge clk) begin
		if (req_fire || !req_valid) begin
			if (gap_left != 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				req <= resolve_item(req_backlog.pop_front());
				req_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: random runs of stall and no stall of random length
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 5);
			rsp_stall <= 1'b1;
		end else begin
			stall_left = $urandom_range(0, 24);
			rsp_stall <= 1'b0;
		end
	end

	// Monitor: track register writes, check responses, predict accepted items
	always @(posedge clk) begin
		bam_rsp_t want;
		cycle_count++;
		if (cfg_wr_en) begin
			case (cfg_index)
				REG_BASE:     cfg_base = cfg_data;
				REG_CAPACITY: cfg_cap = cfg_data;
				REG_ALIGN:    cfg_align = cfg_data[3:0];
				REG_GUARD:    cfg_guard = cfg_data[11:0];
				default: ;
			endcase
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("response item with no request pending");
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				reqs_open--;
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("address", want.address, rsp.address);
				check_field("saved_last", want.saved_last, rsp.saved_last);
				check_field("saved_last_valid", 32'(want.saved_last_valid),
					32'(rsp.saved_last_valid));
				check_field("used_bytes", want.used_bytes, rsp.used_bytes);
				check_field("peak_bytes", want.peak_bytes, rsp.peak_bytes);
			end
		end
		req_fire = arst_n && req_valid && !req_stall;
		if (req_fire)
			expected_rsp.push_back(apply_request(req));
	end

	task automatic queue_item(logic [1:0] cmd, logic [31:0] cnt, logic [31:0] esz,
		logic [31:0] tgt, logic [31:0] mtop, logic [31:0] mlast, logic mval, fix_t fix);
		pending_item_t p;
		p.req.command = cmd;
		p.req.count = cnt;
		p.req.elem_size = esz;
		p.req.target_address = tgt;
		p.req.mark_top = mtop;
		p.req.mark_last = mlast;
		p.req.mark_last_valid = mval;
		p.fix = fix;
		req_backlog.push_back(p);
		reqs_open++;
	endtask

	// Mostly well-formed traffic: resizes aimed at the last block, restores
	// to saved marks; the rest random fields
	task automatic queue_random_item(logic [31:0] base);
		int unsigned pick;
		logic [31:0] cnt;
		logic [31:0] esz;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			cnt = $urandom;
			esz = $urandom;
			if (esz == 0)
				esz = 32'd1;
		end else begin
			cnt = $urandom_range(0, 32);
			esz = $urandom_range(1, 64);
		end
		if (pick < 38) begin
			queue_item(CMD_ALLOC, cnt, esz, $urandom, $urandom, $urandom,
				1'($urandom_range(0, 1)), FIX_NONE);
		end else if (pick < 58) begin
			queue_item(CMD_RESIZE, cnt, esz, $urandom, $urandom, $urandom,
				1'($urandom_range(0, 1)),
				($urandom_range(0, 6) != 0) ? FIX_TARGET : FIX_NONE);
		end else if (pick < 75) begin
			queue_item(CMD_SAVE, cnt, esz, $urandom, $urandom, $urandom,
				1'($urandom_range(0, 1)), FIX_NONE);
		end else if (pick < 90) begin
			queue_item(CMD_RESTORE, cnt, esz, $urandom, $urandom, $urandom,
				1'($urandom_range(0, 1)), FIX_MARK);
		end else if (pick < 95) begin
			queue_item(CMD_RESTORE, cnt, esz, $urandom, base + $urandom_range(0, 4096),
				$urandom, 1'($urandom_range(0, 1)), FIX_NONE);
		end else begin
			queue_item(CMD_RESTORE, cnt, esz, $urandom, $urandom, $urandom,
				1'($urandom_range(0, 1)), FIX_NONE);
		end
	endtask

	task automatic wait_idle();
		while (reqs_open != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// One settings phase: reconfigure while idle, then probe the carried-over
	// state, run random traffic and finish with a full arena
	task automatic run_phase(logic [31:0] base, logic [31:0] cap, logic [3:0] align,
		logic [11:0] guard, int unsigned n_random);
		wait_idle();
		write_reg(REG_BASE, base);
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_ALIGN, {28'd0, align});
		write_reg(REG_GUARD, {20'd0, guard});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		// old top may now lie past the end of the shrunken region
		queue_item(CMD_ALLOC, 32'd1, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_RESIZE, 32'd1, 32'd1, '0, '0, '0, 1'b0, FIX_TARGET);
		queue_item(CMD_SAVE, '0, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		// a mark below the base wraps to a huge offset
		queue_item(CMD_RESTORE, '0, 32'd1, '0, base - 32'd1, base, 1'b1, FIX_NONE);
		queue_item(CMD_RESTORE, '0, 32'd1, '0, base, '0, 1'b0, FIX_NONE);
		repeat (n_random) queue_random_item(base);
		queue_item(CMD_ALLOC, '0, 32'd1, '0, '0, '0, 1'b0, FIX_OVER);
		queue_item(CMD_ALLOC, '0, 32'd1, '0, '0, '0, 1'b0, FIX_FIT);
		queue_item(CMD_SAVE, '0, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
	endtask

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("bump_allocator_with_marks_core_tb: errors");
		$finish;
	end

	initial begin
		int unsigned k;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items under the reset settings
		queue_item(CMD_SAVE, '0, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_RESIZE, 32'd1, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_RESTORE, '0, 32'd1, '0, 32'd1, '0, 1'b0, FIX_NONE);
		queue_item(CMD_RESTORE, '0, 32'd1, '0, 32'd0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_ALLOC, 32'd0, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_ALLOC, 32'd1, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_ALLOC, 32'd3, 32'd5, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_RESIZE, 32'd100, 32'd1, '0, '0, '0, 1'b0, FIX_TARGET);
		queue_item(CMD_RESIZE, 32'd0, 32'd1, '0, '0, '0, 1'b0, FIX_TARGET);
		queue_item(CMD_RESIZE, 32'd1, 32'd1, 32'hFFFF_FFFF, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_RESIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, 1'b0,
			FIX_TARGET);
		queue_item(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_ALLOC, 32'd65536, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_SAVE, '0, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_ALLOC, '0, 32'd1, '0, '0, '0, 1'b0, FIX_OVER);
		queue_item(CMD_ALLOC, '0, 32'd1, '0, '0, '0, 1'b0, FIX_FIT);
		queue_item(CMD_RESIZE, 32'd2, 32'd1, '0, '0, '0, 1'b0, FIX_TARGET);
		queue_item(CMD_RESTORE, '0, 32'd1, '0, '0, '0, 1'b0, FIX_MARK);
		// restore a last block far past the region end, then resize it
		queue_item(CMD_RESTORE, '0, 32'd1, '0, 32'd0, 32'hFFFF_FFFF, 1'b1, FIX_NONE);
		queue_item(CMD_RESIZE, 32'd1, 32'd1, 32'hFFFF_FFFF, '0, '0, 1'b0, FIX_NONE);
		queue_item(CMD_SAVE, '0, 32'd1, '0, '0, '0, 1'b0, FIX_NONE);

		// Settings phases, extremes first
		run_phase(32'h0000_0000, 32'hFFFF_FFFF, 4'd0, 12'd0, 36);
		run_phase(32'hFFFF_F000, 32'd65536, 4'd12, 12'd4095, 36);
		run_phase($urandom, 32'd1, 4'd3, 12'd0, 24);
		run_phase($urandom, $urandom_range(4096, 200000), 4'($urandom_range(0, 12)),
			12'($urandom_range(0, 4095)), 36);
		run_phase(32'hFFFF_FFFF, 32'h0000_8000, 4'd12, 12'd64, 36);
		run_phase(BASE_RST, CAPACITY_RST, ALIGN_RST, GUARD_RST, 36);
		for (k = 0; k < 3; k++) begin
			run_phase($urandom, $urandom_range(1, 300000), 4'($urandom_range(0, 12)),
				12'($urandom_range(0, 4095)), 36);
		end

		wait_idle();
		repeat (8) @(negedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("bump_allocator_with_marks_core_tb: clean");
		end else begin
			$display("bump_allocator_with_marks_core_tb: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bam_pkg.sv
hw/rtl/bam_exec.sv
hw/rtl/bump_allocator_with_marks_core.sv
tb/bump_allocator_with_marks_core_tb.sv
